// ===== hw/rtl/gamepad_frame_rle_encoder_unit_macros.svh =====
// assertion macros shared by the gamepad frame encoder modules
// expects clk_i and rst_ni in the scope of every use
`ifndef GAMEPAD_FRAME_RLE_ENCODER_UNIT_MACROS_SVH
`define GAMEPAD_FRAME_RLE_ENCODER_UNIT_MACROS_SVH

// property checked at every edge outside reset
`define GFRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define GFRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gfre_pkg.sv =====
// shared types, constants and encode functions for the gamepad frame encoder
// no dependencies
package gfre_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  localparam logic [3:0]  HAT_RELEASED   = 4'd8;
  localparam logic [15:0] JOY_CENTRE     = 16'h8080;
  localparam logic [15:0] MAX_RUNS_RESET = 16'd4000;
  localparam logic [15:0] RUNS_CEIL      = 16'hFFFF;

  localparam logic [11:0] BUTTON_MAP [12] = '{
    12'h004, 12'h002, 12'h008, 12'h001, 12'h400, 12'h800,
    12'h010, 12'h020, 12'h040, 12'h080, 12'h200, 12'h100
  };
  localparam logic [3:0] HAT_MAP [4] = '{4'd6, 4'd0, 4'd2, 4'd4};

  typedef struct packed {
    logic        toggle;
    logic [11:0] buttons;
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  hat;
  } frame_t;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] buttons;
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  hat;
    logic [15:0] repeats;
    logic [15:0] total;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } push_t;

  function automatic logic [11:0] encode_buttons(logic [15:0] keys);
    logic [11:0] btn;
    btn = '0;
    for (int i = 0; i < 12; i++) begin
      if (keys[i]) begin
        btn = btn | BUTTON_MAP[i];
      end
    end
    return btn;
  endfunction

  // last held d-pad bit wins
  function automatic logic [3:0] encode_hat(logic [15:0] keys);
    logic [3:0] hat;
    hat = HAT_RELEASED;
    for (int i = 0; i < 4; i++) begin
      if (keys[12 + i]) begin
        hat = HAT_MAP[i];
      end
    end
    return hat;
  endfunction

  // floor((s + 32767) * 255 / 65534); 65534 = 2^16 - 2 so the remainder
  // is the low half plus twice the high part, needing one correction
  function automatic logic [7:0] scale_axis(logic signed [15:0] s);
    logic [15:0] x;
    logic [23:0] y;
    logic [7:0]  q0;
    logic [16:0] r;
    logic [7:0]  q;
    x  = {~s[15], s[14:0]} - 16'd1;
    y  = {x, 8'h00} - {8'h00, x};
    q0 = y[23:16];
    r  = {1'b0, y[15:0]} + {8'h00, q0, 1'b0};
    q  = (r >= 17'd65534) ? (q0 + 8'd1) : q0;
    if (s == 16'sd0) begin
      q = 8'd128;
    end else if (s == 16'sh8000) begin
      q = 8'd0;
    end
    return q;
  endfunction

endpackage

// ===== hw/rtl/gfre_frame_stage.sv =====
// input register: encodes one controller frame and holds it for the run core
// depends on gfre_pkg
module gfre_frame_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         held_keys_i,
  input  logic signed [15:0]  left_x_i,
  input  logic signed [15:0]  left_y_i,
  input  logic signed [15:0]  right_x_i,
  input  logic signed [15:0]  right_y_i,
  input  logic                take_i,
  output logic                frame_valid_o,
  output gfre_pkg::frame_t    frame_o
);

  logic             valid_q, valid_d;
  logic             load;
  gfre_pkg::frame_t frame_q, frame_d;

  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    frame_d.toggle  = held_keys_i[4] & held_keys_i[5];
    frame_d.buttons = gfre_pkg::encode_buttons(held_keys_i);
    frame_d.hat     = gfre_pkg::encode_hat(held_keys_i);
    frame_d.left    = {gfre_pkg::scale_axis(left_y_i), gfre_pkg::scale_axis(left_x_i)};
    frame_d.right   = {gfre_pkg::scale_axis(right_y_i), gfre_pkg::scale_axis(right_x_i)};
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_d;
    end
  end

  assign frame_valid_o = valid_q;
  assign frame_o       = frame_q;

endmodule

// ===== hw/rtl/gfre_run_core.sv =====
// run-length state: logging toggle, previous frame, repeat and run counters
// depends on gfre_pkg and the assertion macro header
`include "gamepad_frame_rle_encoder_unit_macros.svh"

module gfre_run_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             frame_valid_i,
  input  gfre_pkg::frame_t frame_i,
  input  logic             space_i,
  output logic             take_o,
  output gfre_pkg::push_t  push_o
);

  logic        max_runs_q;
  logic [15:0] max_runs_r_q;
  logic        logging_q, logging_d;
  logic [11:0] prev_btn_q, prev_btn_d;
  logic [15:0] prev_left_q, prev_left_d;
  logic [15:0] prev_right_q, prev_right_d;
  logic [3:0]  prev_hat_q, prev_hat_d;
  logic [15:0] repeats_q, repeats_d;
  logic [15:0] runs_q, runs_d;

  logic            go;
  logic [15:0]     limit;
  logic            log_mid;
  logic [15:0]     runs_a, runs_b;
  logic            same, run_rec, close_lim;
  logic [1:0]      cnt;
  gfre_pkg::rec_t  trec, rrec, crec, first, second;

  assign go     = frame_valid_i & space_i;
  assign take_o = go;

  // a zero limit behaves as one
  assign limit   = (max_runs_r_q == 16'd0) ? 16'd1 : max_runs_r_q;
  assign log_mid = logging_q ^ frame_i.toggle;
  assign runs_a  = frame_i.toggle ? 16'd0 : runs_q;
  assign same    = (frame_i.buttons == prev_btn_q) && (frame_i.left == prev_left_q) &&
                   (frame_i.right == prev_right_q) && (frame_i.hat == prev_hat_q);
  assign run_rec = log_mid & ~same;
  // run counter saturates instead of wrapping
  assign runs_b  = (run_rec && (runs_a != gfre_pkg::RUNS_CEIL)) ? (runs_a + 16'd1) : runs_a;
  assign close_lim = log_mid & (runs_b > limit);
  assign cnt = {1'b0, frame_i.toggle} + {1'b0, run_rec} + {1'b0, close_lim};

  always_comb begin
    trec       = '0;
    trec.kind  = log_mid ? gfre_pkg::KIND_OPEN : gfre_pkg::KIND_CLOSE;
    trec.total = log_mid ? 16'd0 : runs_q;

    rrec         = '0;
    rrec.kind    = gfre_pkg::KIND_RUN;
    rrec.buttons = prev_btn_q;
    rrec.left    = prev_left_q;
    rrec.right   = prev_right_q;
    rrec.hat     = prev_hat_q;
    rrec.repeats = repeats_q;

    crec       = '0;
    crec.kind  = gfre_pkg::KIND_CLOSE;
    crec.total = runs_b;

    // toggle record comes first, then the run record, then a limit close
    first = frame_i.toggle ? trec : (run_rec ? rrec : crec);
    second = (frame_i.toggle && run_rec) ? rrec : crec;
    first.last  = (cnt == 2'd1);
    second.last = 1'b1;

    push_o.count  = go ? cnt : 2'd0;
    push_o.first  = first;
    push_o.second = second;
  end

  always_comb begin
    logging_d    = logging_q;
    prev_btn_d   = prev_btn_q;
    prev_left_d  = prev_left_q;
    prev_right_d = prev_right_q;
    prev_hat_d   = prev_hat_q;
    repeats_d    = repeats_q;
    runs_d       = runs_q;
    if (go) begin
      logging_d = log_mid & ~close_lim;
      runs_d    = close_lim ? 16'd0 : runs_b;
      if (run_rec) begin
        prev_btn_d   = frame_i.buttons;
        prev_left_d  = frame_i.left;
        prev_right_d = frame_i.right;
        prev_hat_d   = frame_i.hat;
        repeats_d    = 16'd0;
      end else if (log_mid) begin
        repeats_d = repeats_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_runs_q   <= 1'b0;
      max_runs_r_q <= gfre_pkg::MAX_RUNS_RESET;
      logging_q    <= 1'b0;
      prev_btn_q   <= 12'd0;
      prev_left_q  <= gfre_pkg::JOY_CENTRE;
      prev_right_q <= gfre_pkg::JOY_CENTRE;
      prev_hat_q   <= gfre_pkg::HAT_RELEASED;
      repeats_q    <= 16'd0;
      runs_q       <= 16'd0;
    end else begin
      max_runs_q <= cfg_valid_i;
      if (cfg_valid_i) begin
        max_runs_r_q <= cfg_data_i;
      end
      logging_q    <= logging_d;
      prev_btn_q   <= prev_btn_d;
      prev_left_q  <= prev_left_d;
      prev_right_q <= prev_right_d;
      prev_hat_q   <= prev_hat_d;
      repeats_q    <= repeats_d;
      runs_q       <= runs_d;
    end
  end

  `GFRE_ASSERT(a_runs_clear_when_off, !logging_q |-> runs_q == 16'd0, "run count left while off")
  `GFRE_ASSERT_NEXT(a_limit_close_stops, go && close_lim, !logging_q && runs_q == 16'd0, "limit close did not stop logging")
  `GFRE_ASSERT_NEXT(a_cfg_written, max_runs_q, max_runs_r_q == $past(cfg_data_i, 2), "config write lost")

endmodule

// ===== hw/rtl/gfre_out_queue.sv =====
// small result queue taking up to two records per cycle, one out per cycle unless stalled
// depends on gfre_pkg and the assertion macro header
`include "gamepad_frame_rle_encoder_unit_macros.svh"

module gfre_out_queue #(
  parameter int unsigned Depth = gfre_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gfre_pkg::push_t push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gfre_pkg::rec_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gfre_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d, wr_nxt;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : (p + 1'b1);
  endfunction

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  // room for the two records a frame can produce
  assign space_o     = (count_q <= CntW'(Depth - 2));
  assign head_o      = mem_q[rd_q];
  assign wr_nxt      = next_ptr(wr_q);

  always_comb begin
    rd_d    = pop ? next_ptr(rd_q) : rd_q;
    count_d = count_q + CntW'(push_i.count) - CntW'(pop);
    case (push_i.count)
      2'd1:    wr_d = wr_nxt;
      2'd2:    wr_d = next_ptr(wr_nxt);
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nxt] <= push_i.second;
    end
  end

  `GFRE_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `GFRE_ASSERT(a_no_overflow, (push_i.count == 2'd0) || ((count_q + CntW'(push_i.count)) <= CntW'(Depth)), "push into full queue")

endmodule

// ===== hw/rtl/gamepad_frame_rle_encoder_unit.sv =====
// a frame waits in the input register, then its records are written to the output queue
// throughput: one frame per cycle; a frame with two records holds the output for two transfers,
//   and the input stalls while a held frame waits for queue room for two records
// reset: rst_ni asynchronous active low; logging off, centred previous frame, max_runs 4000
// top level: input register, run core and result queue; depends on gfre_pkg
module gamepad_frame_rle_encoder_unit #(
  parameter int unsigned QueueDepth = gfre_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        held_keys_i,
  input  logic signed [15:0] left_x_i,
  input  logic signed [15:0] left_y_i,
  input  logic signed [15:0] right_x_i,
  input  logic signed [15:0] right_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         record_kind_o,
  output logic [11:0]        button_word_o,
  output logic [15:0]        left_word_o,
  output logic [15:0]        right_word_o,
  output logic [3:0]         hat_code_o,
  output logic [15:0]        repeat_count_o,
  output logic [15:0]        run_total_o,
  output logic               last_of_item_o
);

  logic             frame_valid;
  gfre_pkg::frame_t frame;
  logic             take;
  logic             space;
  gfre_pkg::push_t  push;
  gfre_pkg::rec_t   head;

  assign cfg_ready_o = 1'b1;

  gfre_frame_stage u_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .held_keys_i   (held_keys_i),
    .left_x_i      (left_x_i),
    .left_y_i      (left_y_i),
    .right_x_i     (right_x_i),
    .right_y_i     (right_y_i),
    .take_i        (take),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  gfre_run_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .space_i       (space),
    .take_o        (take),
    .push_o        (push)
  );

  gfre_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign record_kind_o  = head.kind;
  assign button_word_o  = head.buttons;
  assign left_word_o    = head.left;
  assign right_word_o   = head.right;
  assign hat_code_o     = head.hat;
  assign repeat_count_o = head.repeats;
  assign run_total_o    = head.total;
  assign last_of_item_o = head.last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for gamepad_frame_rle_encoder_unit: predicts every record from the frames sent
// depends on gfre_pkg for the record kinds and reset constants
module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // destination bit of each raw button, and the code of each d-pad bit
  localparam int         BTN_POS   [12] = '{2, 1, 3, 0, 10, 11, 4, 5, 6, 7, 9, 8};
  localparam logic [3:0] DPAD_CODE [4]  = '{4'd6, 4'd0, 4'd2, 4'd4};

  typedef struct {
    logic [15:0]        keys;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } stick_frame_t;

  typedef struct {
    gfre_pkg::kind_e kind;
    logic [11:0]     buttons;
    logic [15:0]     left;
    logic [15:0]     right;
    logic [3:0]      hat;
    logic [15:0]     repeats;
    logic [15:0]     total;
    logic            last;
  } pad_record_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [15:0]        held_keys_i;
  logic signed [15:0] left_x_i;
  logic signed [15:0] left_y_i;
  logic signed [15:0] right_x_i;
  logic signed [15:0] right_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         record_kind_o;
  logic [11:0]        button_word_o;
  logic [15:0]        left_word_o;
  logic [15:0]        right_word_o;
  logic [3:0]         hat_code_o;
  logic [15:0]        repeat_count_o;
  logic [15:0]        run_total_o;
  logic               last_of_item_o;

  // encoder state as the predictor sees it
  logic        log_open     = 1'b0;
  logic [11:0] last_buttons = '0;
  logic [15:0] last_left    = gfre_pkg::JOY_CENTRE;
  logic [15:0] last_right   = gfre_pkg::JOY_CENTRE;
  logic [3:0]  last_hat     = gfre_pkg::HAT_RELEASED;
  logic [15:0] run_repeats  = '0;
  logic [15:0] runs_logged  = '0;
  logic [15:0] max_runs_cfg = gfre_pkg::MAX_RUNS_RESET;

  pad_record_t  expected_recs [$];
  stick_frame_t last_sent;
  bit           idle_in  = 1'b1;
  bit           stall_on = 1'b1;
  int unsigned  errors, cycles, frames_sent, records_checked;
  int unsigned  run_recs, open_recs, close_recs;

  gamepad_frame_rle_encoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .held_keys_i    (held_keys_i),
    .left_x_i       (left_x_i),
    .left_y_i       (left_y_i),
    .right_x_i      (right_x_i),
    .right_y_i      (right_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .button_word_o  (button_word_o),
    .left_word_o    (left_word_o),
    .right_word_o   (right_word_o),
    .hat_code_o     (hat_code_o),
    .repeat_count_o (repeat_count_o),
    .run_total_o    (run_total_o),
    .last_of_item_o (last_of_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d records still awaited", $time, expected_recs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] scaled_axis(input logic signed [15:0] s);
    int shifted;
    shifted = int'(s) + 32767;
    if (s == 16'sd0) return 8'd128;
    if (shifted <= 0) return 8'd0;
    return 8'((shifted * 255) / 65534);
  endfunction

  function automatic pad_record_t make_record(input gfre_pkg::kind_e kind,
                                              input logic [11:0] btn,
                                              input logic [15:0] lw, rw,
                                              input logic [3:0] hat,
                                              input logic [15:0] rep, tot);
    pad_record_t rec;
    rec.kind    = kind;
    rec.buttons = btn;
    rec.left    = lw;
    rec.right   = rw;
    rec.hat     = hat;
    rec.repeats = rep;
    rec.total   = tot;
    rec.last    = 1'b0;
    return rec;
  endfunction

  task automatic predict_frame(input stick_frame_t f);
    pad_record_t recs [$];
    logic [11:0] btn;
    logic [3:0]  hat;
    logic [15:0] lw, rw, limit;
    limit = (max_runs_cfg == 16'd0) ? 16'd1 : max_runs_cfg;
    if (f.keys[5:4] == 2'b11) begin
      log_open = !log_open;
      if (log_open) begin
        recs.push_back(make_record(gfre_pkg::KIND_OPEN, '0, '0, '0, '0, '0, '0));
      end else begin
        recs.push_back(make_record(gfre_pkg::KIND_CLOSE, '0, '0, '0, '0, '0, runs_logged));
      end
      runs_logged = '0;
    end
    if (log_open) begin
      btn = '0;
      hat = gfre_pkg::HAT_RELEASED;
      for (int i = 0; i < 12; i++) if (f.keys[i]) btn[BTN_POS[i]] = 1'b1;
      for (int i = 0; i < 4; i++) if (f.keys[12 + i]) hat = DPAD_CODE[i];
      lw = {scaled_axis(f.ly), scaled_axis(f.lx)};
      rw = {scaled_axis(f.ry), scaled_axis(f.rx)};
      if (btn == last_buttons && lw == last_left && rw == last_right && hat == last_hat) begin
        run_repeats = run_repeats + 16'd1;
      end else begin
        recs.push_back(make_record(gfre_pkg::KIND_RUN, last_buttons, last_left, last_right,
                                   last_hat, run_repeats, '0));
        last_buttons = btn;
        last_left    = lw;
        last_right   = rw;
        last_hat     = hat;
        run_repeats  = '0;
        if (runs_logged != 16'hFFFF) runs_logged = runs_logged + 16'd1;
      end
      if (runs_logged > limit) begin
        recs.push_back(make_record(gfre_pkg::KIND_CLOSE, '0, '0, '0, '0, '0, runs_logged));
        log_open    = 1'b0;
        runs_logged = '0;
      end
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[k]) expected_recs.push_back(recs[k]);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_records
    pad_record_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected record, kind %0d, expected none, actual present",
                 $time, record_kind_o);
        errors++;
      end else begin
        want = expected_recs.pop_front();
        check_field("record_kind", 16'(want.kind), 16'(record_kind_o));
        check_field("button_word", 16'(want.buttons), 16'(button_word_o));
        check_field("left_word", want.left, left_word_o);
        check_field("right_word", want.right, right_word_o);
        check_field("hat_code", 16'(want.hat), 16'(hat_code_o));
        check_field("repeat_count", want.repeats, repeat_count_o);
        check_field("run_total", want.total, run_total_o);
        check_field("last_of_item", 16'(want.last), 16'(last_of_item_o));
        records_checked++;
        case (want.kind)
          gfre_pkg::KIND_OPEN:  open_recs++;
          gfre_pkg::KIND_CLOSE: close_recs++;
          default:              run_recs++;
        endcase
      end
    end
  end

  // receiver back-pressure, with stretches of none
  initial begin : out_stall_drive
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = stall_on ? $urandom_range(0, 14) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 47) == 0) stall_on = !stall_on;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_frame(input stick_frame_t f);
    int gap;
    gap = idle_in ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    held_keys_i <= f.keys;
    left_x_i    <= f.lx;
    left_y_i    <= f.ly;
    right_x_i   <= f.rx;
    right_y_i   <= f.ry;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(f);
    last_sent = f;
    frames_sent++;
    if ($urandom_range(0, 63) == 0) idle_in = !idle_in;
  endtask

  task automatic send_keys(input logic [15:0] keys, input logic signed [15:0] lx, ly, rx, ry);
    stick_frame_t f;
    f.keys = keys;
    f.lx   = lx;
    f.ly   = ly;
    f.rx   = rx;
    f.ry   = ry;
    send_frame(f);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_recs.size() != 0) @(posedge clk_i);
    // a frame that gives no record may still be inside the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_runs(input logic [15:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    max_runs_cfg = value;
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return 16'sh7FFF;
      3:       return 16'sd0;
      4:       return -16'sd1;
      5:       return 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // random frame; stick clicks held together only when a toggle is wanted
  function automatic stick_frame_t random_frame(input bit toggle);
    stick_frame_t f;
    f.keys = 16'($urandom);
    f.lx   = pick_axis();
    f.ly   = pick_axis();
    f.rx   = pick_axis();
    f.ry   = pick_axis();
    if (toggle) begin
      f.keys[5:4] = 2'b11;
    end else if (f.keys[5:4] == 2'b11) begin
      f.keys[$urandom_range(4, 5)] = 1'b0;
    end
    return f;
  endfunction

  task automatic test_directed_frames();
    send_keys(16'h0001, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // ignored while closed
    send_keys(16'h0030, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // open, then a new run
    send_keys(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // repeats
    send_keys(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'h0FCF, 16'sh8000, 16'sh7FFF, 16'sh8001, -16'sd1);   // all plain buttons
    send_keys(16'h0010, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000);       // one click alone
    send_keys(16'h0020, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_keys(16'h1000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_keys(16'h2000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'h4000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'hF000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // highest d-pad bit wins
    send_keys(16'h5000, 16'sh4000, -16'sh4000, 16'sh0100, -16'sh0100);
    send_keys(16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // close, no run
    send_keys(16'hFFFF, 16'sh1234, 16'sh5678, -16'sh1234, -16'sh5678); // reopen, new run
    send_keys(16'h0030, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // close
    send_keys(16'h0030, 16'sd0, 16'sd0, 16'sd0, 16'sd0);              // reopen, new run
    send_keys(16'h0030, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
  endtask

  // limit of zero behaves as one: second run closes the log in the same frame
  task automatic test_zero_limit();
    write_max_runs(16'd0);
    send_keys(16'h0030, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
    send_keys(16'h0001, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'h0002, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_keys(16'h0003, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_runs(input logic [15:0] limit, input int count);
    stick_frame_t f;
    int choice;
    write_max_runs(limit);
    for (int n = 0; n < count; n++) begin
      choice = $urandom_range(0, 99);
      if (!log_open) begin
        f = random_frame(choice < 60);
      end else if (choice < 35) begin
        f = last_sent;
        if (f.keys[5:4] == 2'b11) f.keys[5] = 1'b0;
      end else if (choice < 50) begin
        // small nudges often scale to the same byte
        f = last_sent;
        if (f.keys[5:4] == 2'b11) f.keys[4] = 1'b0;
        f.lx = f.lx + 16'sd1;
        if ($urandom_range(0, 1) == 1) f.ry = f.ry - 16'sd2;
      end else if (choice < 53) begin
        f = random_frame(1'b1);
      end else begin
        f = random_frame(1'b0);
      end
      send_frame(f);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    held_keys_i = '0;
    left_x_i    = '0;
    left_y_i    = '0;
    right_x_i   = '0;
    right_y_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_zero_limit();
    test_random_runs(16'd0, 200);
    test_random_runs(16'd1, 250);
    test_random_runs(16'hFFFF, 250);
    test_random_runs(16'd3, 250);
    test_random_runs(16'hFFFE, 200);
    test_random_runs(16'($urandom_range(2, 12)), 300);
    test_random_runs(16'($urandom_range(20, 60)), 300);
    test_random_runs(16'($urandom), 200);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_recs.size() != 0) begin
      $display("%0t: %0d records never arrived", $time, expected_recs.size());
      errors++;
    end
    $display("sent %0d frames over nine run limits; checked %0d records", frames_sent,
             records_checked);
    $display("(%0d runs, %0d opens, %0d closes), %0d mismatches", run_recs, open_recs,
             close_recs, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
